FILE: src/sliding_window_reorder_receiver_macros.svh
// Assertion macros shared by the sliding window reorder receiver RTL.
`ifndef SLIDING_WINDOW_REORDER_RECEIVER_MACROS_SVH
`define SLIDING_WINDOW_REORDER_RECEIVER_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked on every rising clock edge outside reset.
`define SWRR_ASSERT_IMP(label, clk, rst, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
    else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define SWRR_ASSERT_NEXT(label, clk, rst, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
    else $error(msg);

`else

`define SWRR_ASSERT_IMP(label, clk, rst, cond, conseq, msg)
`define SWRR_ASSERT_NEXT(label, clk, rst, cond, conseq, msg)

`endif

`endif

FILE: src/swrr_pkg.sv
// Types and constants of the sliding window reorder receiver.
package swrr_pkg;

  localparam int unsigned SEQ_SPACE = 8;
  localparam int unsigned SEQ_BITS  = 3;

  // At most this many slots are delivered for one item.
  localparam logic [SEQ_BITS-1:0] MAX_DELIV = 3'd7;

  localparam logic [2:0] WINDOW_SIZE_RESET = 3'd4;

  localparam logic KIND_DELIVER = 1'b0;
  localparam logic KIND_ACK     = 1'b1;

  localparam logic signed [8:0] ECHO_REJECT = -9'sd1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_READ,
    S_DELIV,
    S_ACK
  } state_t;

  typedef struct packed {
    logic                we;
    logic [SEQ_BITS-1:0] waddr;
    logic                rd_en;
    logic                clr;
    logic [SEQ_BITS-1:0] raddr;
  } store_ctrl_t;

endpackage

FILE: src/swrr_slot_store.sv
// Slot payload memory and slot valid bits of the reorder window.
module swrr_slot_store #(
  parameter int unsigned PAYLOAD_BITS = 64
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  swrr_pkg::store_ctrl_t                ctrl,
  input  logic [PAYLOAD_BITS-1:0]              wdata,
  output logic [PAYLOAD_BITS-1:0]              rdata,
  output logic [swrr_pkg::SEQ_SPACE-1:0]       slot_valid
);

  logic [PAYLOAD_BITS-1:0] mem [swrr_pkg::SEQ_SPACE];

  always_ff @(posedge clk) begin
    if (ctrl.we) begin
      mem[ctrl.waddr] <= wdata;
    end
    if (ctrl.rd_en) begin
      rdata <= mem[ctrl.raddr];
    end
  end

  // A write and a clear never fall in the same cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
    end else begin
      if (ctrl.we) begin
        slot_valid[ctrl.waddr] <= 1'b1;
      end
      if (ctrl.clr) begin
        slot_valid[ctrl.raddr] <= 1'b0;
      end
    end
  end

endmodule

FILE: src/sliding_window_reorder_receiver.sv
// Top level of the sliding window reorder receiver.
//
// Receiver half of a selective-repeat link. Each input item is one packet: a
// checksum flag, a 3-bit sequence number, an 8-bit echo number and a payload
// word. A packet with a good checksum whose sequence number lies fewer than
// window_size slots ahead of the window base (modulo 8) is stored in its slot;
// then the marked slots from the base onward are delivered in order as items
// of kind 0, up to seven per packet, and the base moves past each of them.
// Every packet ends with exactly one acknowledgement item of kind 1 with last
// set, carrying the new base and the echo number, or -1 as echo when the
// packet was rejected. A packet passes a check state, if stored then read
// states and one delivery state per drained slot, then an acknowledge state,
// which output stalls hold as they do delivery. The sequencer walks the slots
// one at a time through a single 3-bit adder (window offset and base
// increment) and a slot memory with a registered read port. in_ready is high
// only while no packet is being worked on. The output register lets the last
// acknowledgement wait for out_ready while the next packet is already taken.
// window_size may be written through cfg_we/cfg_data only while the block
// is idle; its reset value is 4. The slot valid bits are cleared by reset.
`include "sliding_window_reorder_receiver_macros.svh"

module sliding_window_reorder_receiver #(
  parameter int unsigned PAYLOAD_BITS = 64
) (
  input  logic                clk,
  input  logic                rst,

  input  logic                cfg_we,
  input  logic [2:0]          cfg_data,

  input  logic                in_valid,
  output logic                in_ready,
  input  logic                checksum_ok,
  input  logic [2:0]          seq_num,
  input  logic [7:0]          echo_num,
  input  logic [63:0]         payload,

  output logic                out_valid,
  input  logic                out_ready,
  output logic                kind,
  output logic [63:0]         out_payload,
  output logic [2:0]          ack_base,
  output logic signed [8:0]   ack_echo,
  output logic                last
);

  swrr_pkg::state_t state, state_next;

  logic [2:0]                           window_size;
  logic [swrr_pkg::SEQ_BITS-1:0]        base;
  logic [swrr_pkg::SEQ_BITS-1:0]        count;

  // Packet held while it is worked on.
  logic                                 pkt_ok;
  logic [swrr_pkg::SEQ_BITS-1:0]        pkt_seq;
  logic [7:0]                           pkt_echo;
  logic [PAYLOAD_BITS-1:0]              pkt_payload;
  logic signed [8:0]                    echo_q;

  logic [PAYLOAD_BITS-1:0]              rdata;
  logic [swrr_pkg::SEQ_SPACE-1:0]       slot_valid;
  swrr_pkg::store_ctrl_t                store_ctrl;

  // The one shared adder: window offset in the check step, base increment
  // when a slot is delivered.
  logic [swrr_pkg::SEQ_BITS-1:0]        add_a, add_b, add_sum;
  logic                                 in_win;
  logic                                 out_free;
  logic                                 load_deliv, load_ack;

  assign add_sum  = add_a + add_b;
  assign in_win   = pkt_ok && (add_sum < window_size);
  assign out_free = !out_valid || out_ready;

  swrr_slot_store #(
    .PAYLOAD_BITS(PAYLOAD_BITS)
  ) u_store (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (store_ctrl),
    .wdata      (pkt_payload),
    .rdata      (rdata),
    .slot_valid (slot_valid)
  );

  // Operands of the shared adder: the distance of the packet ahead of the
  // base while checking, otherwise the base plus one.
  always_comb begin
    if (state == swrr_pkg::S_CHECK) begin
      add_a = pkt_seq;
      add_b = ~base + {{(swrr_pkg::SEQ_BITS-1){1'b0}}, 1'b1};
    end else begin
      add_a = base;
      add_b = {{(swrr_pkg::SEQ_BITS-1){1'b0}}, 1'b1};
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      swrr_pkg::S_IDLE: begin
        if (in_valid) begin
          state_next = swrr_pkg::S_CHECK;
        end
      end
      swrr_pkg::S_CHECK: begin
        state_next = in_win ? swrr_pkg::S_READ : swrr_pkg::S_ACK;
      end
      swrr_pkg::S_READ: begin
        if (count != swrr_pkg::MAX_DELIV && slot_valid[base]) begin
          state_next = swrr_pkg::S_DELIV;
        end else begin
          state_next = swrr_pkg::S_ACK;
        end
      end
      swrr_pkg::S_DELIV: begin
        if (out_free) begin
          state_next = swrr_pkg::S_READ;
        end
      end
      swrr_pkg::S_ACK: begin
        if (out_free) begin
          state_next = swrr_pkg::S_IDLE;
        end
      end
      default: state_next = swrr_pkg::S_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_ready         = 1'b0;
    store_ctrl       = '0;
    store_ctrl.waddr = pkt_seq;
    store_ctrl.raddr = base;
    load_deliv       = 1'b0;
    load_ack         = 1'b0;
    case (state)
      swrr_pkg::S_IDLE: begin
        in_ready = 1'b1;
      end
      swrr_pkg::S_CHECK: begin
        store_ctrl.we = in_win;
      end
      swrr_pkg::S_READ: begin
        store_ctrl.rd_en = (count != swrr_pkg::MAX_DELIV) && slot_valid[base];
      end
      swrr_pkg::S_DELIV: begin
        load_deliv     = out_free;
        store_ctrl.clr = out_free;
      end
      swrr_pkg::S_ACK: begin
        load_ack = out_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= swrr_pkg::S_IDLE;
      window_size <= swrr_pkg::WINDOW_SIZE_RESET;
      base        <= '0;
      count       <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        window_size <= cfg_data;
      end
      if (state == swrr_pkg::S_CHECK) begin
        count <= '0;
      end
      if (load_deliv) begin
        base  <= add_sum;
        count <= count + {{(swrr_pkg::SEQ_BITS-1){1'b0}}, 1'b1};
      end
    end
  end

  // Packet fields and the echo value of the pending acknowledgement.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      pkt_ok      <= checksum_ok;
      pkt_seq     <= seq_num;
      pkt_echo    <= echo_num;
      pkt_payload <= payload[PAYLOAD_BITS-1:0];
    end
    if (state == swrr_pkg::S_CHECK) begin
      echo_q <= in_win ? signed'({1'b0, pkt_echo}) : swrr_pkg::ECHO_REJECT;
    end
  end

  // Output register: loaded with a delivery or an acknowledgement whenever
  // it is empty or being emptied in the same cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_deliv || load_ack) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_deliv) begin
      kind        <= swrr_pkg::KIND_DELIVER;
      out_payload <= 64'(rdata);
      ack_base    <= '0;
      ack_echo    <= '0;
      last        <= 1'b0;
    end else if (load_ack) begin
      kind        <= swrr_pkg::KIND_ACK;
      out_payload <= '0;
      ack_base    <= base;
      ack_echo    <= echo_q;
      last        <= 1'b1;
    end
  end

  // No more than the delivery limit of slots is drained for one packet.
  `SWRR_ASSERT_IMP(a_deliv_limit, clk, rst, state == swrr_pkg::S_DELIV, count != swrr_pkg::MAX_DELIV, "delivery limit exceeded")

  // A delivered slot is cleared in the cycle after it is handed out.
  `SWRR_ASSERT_NEXT(a_slot_cleared, clk, rst, load_deliv, !slot_valid[$past(base)], "delivered slot still marked")

  // The window base moves only when a slot is delivered.
  `SWRR_ASSERT_NEXT(a_base_hold, clk, rst, !load_deliv, $stable(base), "window base moved without delivery")

  // A rejected packet never stores its payload.
  `SWRR_ASSERT_IMP(a_reject_no_store, clk, rst, (state == swrr_pkg::S_CHECK) && !pkt_ok, !store_ctrl.we, "rejected packet written to a slot")

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the sliding window reorder receiver.
module testbench;

  // The slowest correct run is far below this: every packet can drain seven
  // slots and each result can wait out a long output stall.
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  // Cycles to linger after the last result so that stray results get caught.
  localparam int unsigned TAIL_CYCLES = 40;

  // One result item as seen on the output channel.
  typedef struct packed {
    logic               kind;
    logic [63:0]        data;
    logic [2:0]         base;
    logic signed [8:0]  echo;
    logic               last;
  } result_t;

  logic               clk;
  logic               rst;
  logic               cfg_we;
  logic [2:0]         cfg_data;
  logic               in_valid;
  logic               in_ready;
  logic               checksum_ok;
  logic [2:0]         seq_num;
  logic [7:0]         echo_num;
  logic [63:0]        payload;
  logic               out_valid;
  logic               out_ready;
  logic               kind;
  logic [63:0]        out_payload;
  logic [2:0]         ack_base;
  logic signed [8:0]  ack_echo;
  logic               last;

  sliding_window_reorder_receiver i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .checksum_ok (checksum_ok),
    .seq_num     (seq_num),
    .echo_num    (echo_num),
    .payload     (payload),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .kind        (kind),
    .out_payload (out_payload),
    .ack_base    (ack_base),
    .ack_echo    (ack_echo),
    .last        (last)
  );

  // Our own copy of the receiver state, advanced at every accepted packet.
  logic [63:0]  slot_data [swrr_pkg::SEQ_SPACE];
  logic         slot_full [swrr_pkg::SEQ_SPACE];
  logic [2:0]   next_base;
  logic [2:0]   win_size;

  // Results that the block still owes us, oldest first.
  result_t      pending_results[$];

  int unsigned  err_count;
  int unsigned  cycle_count;

  // Idle controls: when clear, the matching side runs back to back.
  bit           in_idle_on;
  bit           out_stall_on;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog. A hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[sliding_window_reorder_receiver] ERROR");
      $finish;
    end
  end

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Output side back-pressure. Exactly one assignment to out_ready per edge,
  // and a stall, once started, is held for its whole length.
  initial begin
    int unsigned hold;
    hold = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        hold--;
        out_ready <= 1'b0;
      end else if (out_stall_on && $urandom_range(0, 4) == 0) begin
        hold = pick_gap();
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic report_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    err_count++;
  endtask

  // Every result item that crosses the output handshake is matched against
  // the oldest outstanding prediction.
  always @(posedge clk) begin
    result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result item, expected none, actual kind %0b data %0h",
                 $time, kind, out_payload);
        err_count++;
      end else begin
        want = pending_results.pop_front();
        if (kind !== want.kind) report_field("kind", 64'(want.kind), 64'(kind));
        if (out_payload !== want.data) report_field("out_payload", want.data, out_payload);
        if (ack_base !== want.base) report_field("ack_base", 64'(want.base), 64'(ack_base));
        if (ack_echo !== want.echo) report_field("ack_echo", 64'(want.echo), 64'(ack_echo));
        if (last !== want.last) report_field("last", 64'(want.last), 64'(last));
      end
    end
  end

  // Work out what one accepted packet must produce. A packet is taken when the
  // checksum is good and its distance ahead of the base, counted modulo the
  // sequence space, is below the window size. The marked slots from the base
  // onward then drain in order, at most MAX_DELIV of them per packet, and the
  // acknowledgement always closes the packet.
  task automatic predict_packet(input logic ok, input logic [2:0] seq,
                                input logic [7:0] echo, input logic [63:0] data);
    logic [2:0]   offset;
    int unsigned  drained;
    result_t      res;
    offset = seq - next_base;
    drained = 0;
    if (ok && offset < win_size) begin
      slot_data[seq] = data;
      slot_full[seq] = 1'b1;
      while (drained < swrr_pkg::MAX_DELIV && slot_full[next_base]) begin
        res = '{kind: swrr_pkg::KIND_DELIVER, data: slot_data[next_base], base: 3'd0,
                echo: 9'sd0, last: 1'b0};
        pending_results.push_back(res);
        slot_full[next_base] = 1'b0;
        next_base = next_base + 3'd1;
        drained++;
      end
      res = '{kind: swrr_pkg::KIND_ACK, data: 64'd0, base: next_base,
              echo: $signed({1'b0, echo}), last: 1'b1};
    end else begin
      res = '{kind: swrr_pkg::KIND_ACK, data: 64'd0, base: next_base,
              echo: swrr_pkg::ECHO_REJECT, last: 1'b1};
    end
    pending_results.push_back(res);
  endtask

  // Present one packet and hold it until the block takes it. in_valid is
  // left high when no gap follows, so back-to-back packets never see it
  // lowered and raised within one time step.
  task automatic send_packet(input logic ok, input logic [2:0] seq,
                             input logic [7:0] echo, input logic [63:0] data);
    int unsigned gap;
    in_valid    <= 1'b1;
    checksum_ok <= ok;
    seq_num     <= seq;
    echo_num    <= echo;
    payload     <= data;
    do @(posedge clk); while (!in_ready);
    predict_packet(ok, seq, echo, data);
    gap = in_idle_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop sending and let every owed result come out. Since each packet ends
  // with an acknowledgement, an empty queue means the block is idle.
  task automatic await_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_window(input logic [2:0] size);
    await_drain();
    cfg_we   <= 1'b1;
    cfg_data <= size;
    @(posedge clk);
    cfg_we   <= 1'b0;
    win_size = size;
  endtask

  // In-order and simple reordered arrival with the reset window of four,
  // including the extremes of echo and payload.
  task automatic test_in_order();
    send_packet(1'b1, 3'd0, 8'd0, 64'd0);
    send_packet(1'b1, 3'd1, 8'd255, {64{1'b1}});
    send_packet(1'b1, 3'd3, 8'h5a, 64'h0123_4567_89ab_cdef);
    send_packet(1'b1, 3'd2, 8'ha5, 64'hfedc_ba98_7654_3210);
  endtask

  // Rejections: bad checksum inside the window, a packet behind the window,
  // and one just past the far edge. The near edge of the window is taken.
  task automatic test_rejects();
    send_packet(1'b0, 3'd4, 8'd17, 64'h1111);
    send_packet(1'b1, 3'd1, 8'd18, 64'h2222);
    send_packet(1'b1, 3'd0, 8'd19, 64'h3333);
    send_packet(1'b1, 3'd7, 8'd20, 64'h8000_0000_0000_0001);
    send_packet(1'b1, 3'd4, 8'd21, 64'h4444);
    send_packet(1'b1, 3'd6, 8'd22, 64'h6666);
    send_packet(1'b1, 3'd5, 8'd23, 64'h5555);
  endtask

  // Widest window: fill six slots ahead of the base, overwrite one of them,
  // then close the gap so the longest drain comes out of a single packet.
  task automatic test_max_burst();
    write_window(3'd7);
    for (int i = 1; i < 7; i++)
      send_packet(1'b1, next_base + 3'(i), 8'(i), {$urandom, $urandom});
    send_packet(1'b1, next_base + 3'd3, 8'd99, 64'hdead_beef_cafe_f00d);
    send_packet(1'b1, next_base, 8'd100, 64'hffff_0000_ffff_0000);
  endtask

  // A window of zero takes nothing; a window of one takes only the base.
  task automatic test_small_windows();
    write_window(3'd0);
    send_packet(1'b1, next_base, 8'd1, 64'h1);
    send_packet(1'b1, next_base + 3'd1, 8'd2, 64'h2);
    send_packet(1'b1, next_base + 3'd7, 8'd3, 64'h3);
    write_window(3'd1);
    send_packet(1'b1, next_base + 3'd1, 8'd4, 64'h4);
    send_packet(1'b1, next_base, 8'd5, 64'h5);
  endtask

  // Random traffic over several window sizes. Most packets are good and land
  // inside the window, often right at the base so the stored slots drain;
  // the rest carry bad checksums or arbitrary sequence numbers.
  task automatic test_random_phases();
    logic [2:0]  wins [9];
    int unsigned count;
    int unsigned roll;
    logic        ok;
    logic [2:0]  seq;
    wins = '{3'd7, 3'd3, 3'd1, 3'd5, 3'd2, 3'd6, 3'd4, 3'd0, 3'd7};
    for (int p = 0; p < 9; p++) begin
      write_window(wins[p]);
      in_idle_on   = (p % 3 != 0);
      out_stall_on = (p % 3 != 1);
      count = (wins[p] == 3'd0) ? 10 : 55;
      for (int n = 0; n < count; n++) begin
        roll = $urandom_range(0, 99);
        ok   = 1'b1;
        if (roll < 80 && win_size != 3'd0) begin
          if ($urandom_range(0, 2) == 0)
            seq = next_base;
          else
            seq = next_base + 3'($urandom_range(0, win_size - 1));
        end else begin
          ok  = (roll < 90) ? 1'b0 : 1'b1;
          seq = 3'($urandom_range(0, 7));
        end
        send_packet(ok, seq, 8'($urandom_range(0, 255)), {$urandom, $urandom});
        // Now and then hold off until everything owed has come out.
        if ($urandom_range(0, 39) == 0) await_drain();
      end
    end
  endtask

  initial begin
    err_count   = 0;
    cycle_count = 0;
    in_idle_on   = 1'b0;
    out_stall_on = 1'b0;
    win_size  = swrr_pkg::WINDOW_SIZE_RESET;
    next_base = 3'd0;
    for (int i = 0; i < swrr_pkg::SEQ_SPACE; i++) begin
      slot_data[i] = 64'd0;
      slot_full[i] = 1'b0;
    end
    rst         <= 1'b1;
    cfg_we      <= 1'b0;
    cfg_data    <= 3'd0;
    in_valid    <= 1'b0;
    checksum_ok <= 1'b0;
    seq_num     <= 3'd0;
    echo_num    <= 8'd0;
    payload     <= 64'd0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_in_order();
    in_idle_on   = 1'b1;
    out_stall_on = 1'b1;
    test_rejects();
    test_max_burst();
    test_small_windows();
    test_random_phases();

    await_drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("[sliding_window_reorder_receiver] OK");
    end else begin
      $display("[sliding_window_reorder_receiver] ERROR");
    end
    $finish;
  end

endmodule
